@@ src/slal_pkg.sv @@
// shared types, constants and helper functions for the shifting array list
// no dependencies; used by every module of the block

package slal_pkg;

    localparam int CAPACITY_DEF  = 256;
    localparam int ENTRY_W       = 40;
    localparam int COUNT_W       = 9;
    localparam int READ_INDEX_W  = 8;
    localparam int IN_W          = 56;
    localparam int OUT_W         = 136;

    typedef struct packed {
        logic [7:0]         symbol;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } entry_t;

    localparam entry_t DEFAULT_ENTRY = '{symbol: 8'd95, y: 16'sd0, x: 16'sd0};

    typedef enum logic [2:0] {
        CMD_QUERY    = 3'd0,
        CMD_INS_HEAD = 3'd1,
        CMD_INS_TAIL = 3'd2,
        CMD_REM_HEAD = 3'd3,
        CMD_REM_TAIL = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUSY,
        S_HOLD
    } state_t;

    // per-cycle move order broadcast to every cell
    typedef struct packed {
        logic ins_head;
        logic ins_tail;
        logic rem_head;
    } shift_ctl_t;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int pow4(input int e);
        int r;
        r = 1;
        for (int i = 0; i < e; i++) begin
            r = r * 4;
        end
        return r;
    endfunction

    // radix-4 levels needed to reduce n leaves to one
    function automatic int tree_levels(input int n);
        int l;
        l = 1;
        while (pow4(l) < n) begin
            l = l + 1;
        end
        return l;
    endfunction

    // first flat node index of level lvl
    function automatic int tree_offset(input int levels, input int lvl);
        int off;
        off = 0;
        for (int j = 0; j < lvl; j++) begin
            off = off + pow4(levels - 1 - j);
        end
        return off;
    endfunction

endpackage

@@ src/slal_cell.sv @@
// one storage cell of the list: holds one entry, shifts with its neighbors
// depends on slal_pkg

module slal_cell #(
    parameter int CAPACITY = slal_pkg::CAPACITY_DEF,
    parameter int IDX      = 0
) (
    input  logic                       aclk,
    input  slal_pkg::shift_ctl_t       ctl,
    input  slal_pkg::entry_t           fresh,
    input  slal_pkg::entry_t           from_prev,
    input  slal_pkg::entry_t           from_next,
    input  logic [$clog2(CAPACITY+1)-1:0] count_q,
    input  logic [$clog2(CAPACITY)-1:0]   tail_tgt,
    input  logic [slal_pkg::max_int($clog2(CAPACITY), slal_pkg::READ_INDEX_W)-1:0] read_tgt,
    output slal_pkg::entry_t           entry_q,
    output slal_pkg::entry_t           tail_sel,
    output slal_pkg::entry_t           read_sel
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = slal_pkg::max_int(IW, slal_pkg::READ_INDEX_W);

    slal_pkg::entry_t entry_reg;
    slal_pkg::entry_t entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (ctl.ins_head) begin
            entry_next = from_prev;
        end else if (ctl.rem_head) begin
            entry_next = from_next;
        end else if (ctl.ins_tail && (count_q == CW'(IDX))) begin
            entry_next = fresh;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_q  = entry_reg;
    // masked copies feed the or-trees; only the addressed cell is nonzero
    assign tail_sel = (tail_tgt == IW'(IDX))   ? entry_reg : '0;
    assign read_sel = (read_tgt == CMPW'(IDX)) ? entry_reg : '0;

endmodule

@@ src/slal_or_tree.sv @@
// registered radix-4 or-reduction of one-hot masked cell outputs
// depends on slal_pkg

module slal_or_tree #(
    parameter int N = slal_pkg::CAPACITY_DEF
) (
    input  logic             aclk,
    input  slal_pkg::entry_t leaf [N],
    output slal_pkg::entry_t root
);

    localparam int EW     = slal_pkg::ENTRY_W;
    localparam int LEVELS = slal_pkg::tree_levels(N);
    localparam int SPAN   = slal_pkg::pow4(LEVELS);
    localparam int TOTAL  = slal_pkg::tree_offset(LEVELS, LEVELS);

    logic [EW-1:0] pad       [SPAN];
    logic [EW-1:0] node_reg  [TOTAL];
    logic [EW-1:0] node_next [TOTAL];

    for (genvar k = 0; k < SPAN; k++) begin : g_pad
        if (k < N) begin : g_used
            assign pad[k] = leaf[k];
        end else begin : g_zero
            assign pad[k] = '0;
        end
    end

    always_comb begin
        for (int l = 0; l < LEVELS; l++) begin
            for (int n = 0; n < slal_pkg::pow4(LEVELS - 1 - l); n++) begin
                node_next[slal_pkg::tree_offset(LEVELS, l) + n] = '0;
                for (int c = 0; c < 4; c++) begin
                    if (l == 0) begin
                        node_next[n] = node_next[n] | pad[4 * n + c];
                    end else begin
                        node_next[slal_pkg::tree_offset(LEVELS, l) + n] =
                            node_next[slal_pkg::tree_offset(LEVELS, l) + n] |
                            node_reg[slal_pkg::tree_offset(LEVELS, l - 1) + 4 * n + c];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        node_reg <= node_next;
    end

    assign root = slal_pkg::entry_t'(node_reg[TOTAL-1]);

endmodule

@@ src/shifting_array_list_core.sv @@
// top level of the shifting array list: command decode, count, cell row, read trees
// depends on slal_pkg, slal_cell, slal_or_tree

// An ordered list of up to CAPACITY (x, y, symbol) entries kept in a row of cells.
// Each input transfer carries one command (query, insert head, insert tail, remove
// head, remove tail) plus an entry and a read index; each one yields exactly one
// result transfer with status, count, head, tail and the indexed entry as they
// stand after the command. The list itself changes in the cycle the command is
// taken: all cells shift together toward the tail or the head, or the cell at the
// tail position loads the new entry. The tail and indexed entries are then picked
// out through two registered radix-4 or-trees of L = ceil(log4(CAPACITY)) levels
// (L = 4 at 256 entries). No new command is taken until the result of the last one
// has been loaded into the output register. A result waiting in the output register
// does not block the next command; only when a new result is ready and the previous
// one is still not taken does the block stall.
// Empty list and out-of-range reads return x 0, y 0, symbol '_'.

module shifting_array_list_core #(
    parameter int CAPACITY = slal_pkg::CAPACITY_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // command, entry_x, entry_y, entry_symbol, read_index; zero pad to 56 bits
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [slal_pkg::IN_W-1:0]  s_tdata,
    // status, count, head_x, head_y, head_symbol, tail_x, tail_y, tail_symbol,
    // read_x, read_y, read_symbol, read_valid; zero pad to 136 bits
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [slal_pkg::OUT_W-1:0] m_tdata
);

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int IW     = $clog2(CAPACITY);
    localparam int CMPW   = slal_pkg::max_int(IW, slal_pkg::READ_INDEX_W);
    localparam int RW     = slal_pkg::max_int(CW, slal_pkg::READ_INDEX_W);
    localparam int LEVELS = slal_pkg::tree_levels(CAPACITY);
    localparam int WW     = $clog2(LEVELS + 1);

    // input field split
    slal_pkg::cmd_t   cmd;
    slal_pkg::entry_t fresh;
    logic [slal_pkg::READ_INDEX_W-1:0] in_index;

    assign cmd      = slal_pkg::cmd_t'(s_tdata[2:0]);
    assign fresh    = slal_pkg::entry_t'(s_tdata[42:3]);
    assign in_index = s_tdata[50:43];

    // control and status registers
    slal_pkg::state_t  state_reg, state_next;
    logic [WW-1:0]     wait_reg, wait_next;
    logic [CW-1:0]     count_reg, count_next;
    slal_pkg::status_t status_reg, status_next;
    logic [slal_pkg::READ_INDEX_W-1:0] idx_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [slal_pkg::OUT_W-1:0] m_tdata_reg, m_tdata_next;

    logic                 accept;
    logic                 is_full;
    logic                 is_empty;
    logic                 tree_done;
    logic                 out_free;
    logic                 load_out;
    slal_pkg::shift_ctl_t ctl;

    assign accept    = s_tvalid && s_tready;
    assign is_full   = (count_reg == CW'(CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign tree_done = (wait_reg == WW'(LEVELS));
    assign out_free  = !m_tvalid_reg || m_tready;

    // command decode: move order for the cells, new count and status
    always_comb begin
        ctl         = '0;
        count_next  = count_reg;
        status_next = slal_pkg::ST_DONE;
        if (accept) begin
            unique case (cmd) inside
                slal_pkg::CMD_INS_HEAD, slal_pkg::CMD_INS_TAIL: begin
                    if (is_full) begin
                        status_next = slal_pkg::ST_FULL;
                    end else begin
                        count_next   = count_reg + 1'b1;
                        ctl.ins_head = (cmd == slal_pkg::CMD_INS_HEAD);
                        ctl.ins_tail = (cmd == slal_pkg::CMD_INS_TAIL);
                    end
                end
                slal_pkg::CMD_REM_HEAD, slal_pkg::CMD_REM_TAIL: begin
                    if (is_empty) begin
                        status_next = slal_pkg::ST_EMPTY;
                    end else begin
                        count_next   = count_reg - 1'b1;
                        ctl.rem_head = (cmd == slal_pkg::CMD_REM_HEAD);
                    end
                end
                default: begin
                    // query and unused codes leave the list alone
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // per-command payload, held until the result is built
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            idx_reg    <= in_index;
        end
    end

    // cell row
    logic [IW-1:0]    tail_tgt;
    logic [CMPW-1:0]  read_tgt;
    slal_pkg::entry_t cell_q   [CAPACITY];
    slal_pkg::entry_t tail_sel [CAPACITY];
    slal_pkg::entry_t read_sel [CAPACITY];

    // tail position wraps when empty; the empty default masks it then
    assign tail_tgt = IW'(count_reg - 1'b1);
    assign read_tgt = CMPW'(idx_reg);

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        slal_pkg::entry_t prev_e;
        slal_pkg::entry_t next_e;

        if (k == 0) begin : g_first
            assign prev_e = fresh;
        end else begin : g_inner_prev
            assign prev_e = cell_q[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign next_e = cell_q[k];
        end else begin : g_inner_next
            assign next_e = cell_q[k+1];
        end

        slal_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (k)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .fresh     (fresh),
            .from_prev (prev_e),
            .from_next (next_e),
            .count_q   (count_reg),
            .tail_tgt  (tail_tgt),
            .read_tgt  (read_tgt),
            .entry_q   (cell_q[k]),
            .tail_sel  (tail_sel[k]),
            .read_sel  (read_sel[k])
        );
    end

    // tail and indexed entry selection
    slal_pkg::entry_t tail_root;
    slal_pkg::entry_t read_root;

    slal_or_tree #(.N(CAPACITY)) u_tail_tree (
        .aclk (aclk),
        .leaf (tail_sel),
        .root (tail_root)
    );

    slal_or_tree #(.N(CAPACITY)) u_read_tree (
        .aclk (aclk),
        .leaf (read_sel),
        .root (read_root)
    );

    // result assembly
    slal_pkg::entry_t out_head;
    slal_pkg::entry_t out_tail;
    slal_pkg::entry_t out_read;
    logic             read_ok;

    assign read_ok  = (RW'(idx_reg) < RW'(count_reg));
    assign out_head = is_empty ? slal_pkg::DEFAULT_ENTRY : cell_q[0];
    assign out_tail = is_empty ? slal_pkg::DEFAULT_ENTRY : tail_root;
    assign out_read = read_ok  ? read_root : slal_pkg::DEFAULT_ENTRY;

    assign m_tdata_next = {4'b0000, read_ok, out_read, out_tail, out_head,
                           slal_pkg::COUNT_W'(count_reg), status_reg};

    // sequencer: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            slal_pkg::S_IDLE: begin
                if (accept) begin
                    state_next = slal_pkg::S_BUSY;
                end
            end
            slal_pkg::S_BUSY: begin
                if (tree_done) begin
                    state_next = out_free ? slal_pkg::S_IDLE : slal_pkg::S_HOLD;
                end
            end
            slal_pkg::S_HOLD: begin
                if (out_free) begin
                    state_next = slal_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = slal_pkg::S_IDLE;
            end
        endcase
    end

    // sequencer: outputs
    always_comb begin
        s_tready  = 1'b0;
        load_out  = 1'b0;
        wait_next = '0;
        unique case (state_reg)
            slal_pkg::S_IDLE: begin
                s_tready = 1'b1;
            end
            slal_pkg::S_BUSY: begin
                wait_next = wait_reg + 1'b1;
                load_out  = tree_done && out_free;
            end
            slal_pkg::S_HOLD: begin
                load_out = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= slal_pkg::S_IDLE;
            wait_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wait_reg     <= wait_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ src/slal_checker.sv @@
// port-level checks for shifting_array_list_core, attached by bind
// depends on slal_pkg and shifting_array_list_core

module slal_checker #(
    parameter int CAPACITY = slal_pkg::CAPACITY_DEF
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [slal_pkg::OUT_W-1:0] m_tdata
);

    // no result comes straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a refused insert only happens on a full list
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == slal_pkg::ST_FULL) |->
            (m_tdata[10:2] == slal_pkg::COUNT_W'(CAPACITY)))
        else $error("insert refused below capacity");

    // a refused removal reports an empty list with default entries
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == slal_pkg::ST_EMPTY) |->
            (m_tdata[10:2] == '0) && !m_tdata[131] && (m_tdata[50:43] == 8'd95) &&
            (m_tdata[90:83] == 8'd95) && (m_tdata[130:123] == 8'd95))
        else $error("removal refused on a nonempty list");

    // an empty list never reports a valid read and reports zero head and tail x (checked below 512 entries)
    a_empty_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (CAPACITY < 512) && m_tvalid && (m_tdata[10:2] == '0) |->
            !m_tdata[131] && (m_tdata[26:11] == '0) && (m_tdata[66:51] == '0))
        else $error("empty list with valid read or nonzero head/tail");

endmodule

bind shifting_array_list_core slal_checker #(.CAPACITY(CAPACITY)) u_slal_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
